FILE: design/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT1/DXT5 block decoder.
// No dependencies; used by every module of the decoder by scoped names.
`default_nettype none

package dxt_pkg;

    localparam int MAX_DIM_BLOCKS_DEF = 8192;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BLOCKS = 2'd1;

    localparam int WIDTH_REG_W = 14;
    localparam int PIX_W       = 15;

    typedef logic [3:0][7:0] t_chan_pal;
    typedef logic [7:0][7:0] t_alpha_lvl;

    typedef struct packed {
        logic adv2;
        logic adv3;
    } t_pipe_ctl;

    typedef struct packed {
        logic [31:0]      cidx;
        logic [47:0]      aidx;
        logic             four;
        logic             dxt5;
        logic [PIX_W-1:0] base_x;
        logic [PIX_W-1:0] base_y;
    } t_blk_side;

    // floor(255*v/31)
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'd2156535;
        return p[25:18];
    endfunction

    // floor(255*v/63)
    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd4244475;
        return p[27:20];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

FILE: design/dxt_texture_block_decoder_top.sv
// Top level of the DXT1/DXT5 texture block decoder: input stage, block placement,
// pipeline control. Depends on dxt_pkg, dxt_color_lane, dxt_alpha_lane, dxt_texel_merge.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_data_word
//   result    out        o_out_valid / i_out_ready  o_red .. o_block_last
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A colour word yields 16 texels, one per cycle while the output is not stalled; the
// single texel output port sets the sustained block rate. An alpha word yields no texels.
// A colour word passes the r_s1, r_s2 and r_s3 registers, the merge capture and the output register.
// Synchronous active-low reset clears all valid flags and block position.
// Input is taken while earlier blocks drain; a stalled output backs up the lanes.
`default_nettype none

module dxt_texture_block_decoder_top #(
    parameter int MAX_DIM_BLOCKS = dxt_pkg::MAX_DIM_BLOCKS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dxt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [13:0]                   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [63:0]                   i_data_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [7:0]                         o_alpha,
    output logic [14:0]                        o_pixel_x,
    output logic [14:0]                        o_pixel_y,
    output logic                               o_block_last
);

    localparam int CW = (MAX_DIM_BLOCKS > 1) ? $clog2(MAX_DIM_BLOCKS) : 1;
    localparam logic [dxt_pkg::WIDTH_REG_W-1:0] MAX_W = dxt_pkg::WIDTH_REG_W'(MAX_DIM_BLOCKS);
    localparam logic [CW:0] MAX_ROWS = (CW + 1)'(MAX_DIM_BLOCKS);

    logic                                r_fmt;
    logic [dxt_pkg::WIDTH_REG_W-1:0]     r_width;
    logic                                r_expect;
    logic [63:0]                         r_held;
    logic [CW-1:0]                       r_col, n_col;
    logic [CW-1:0]                       r_row, n_row;

    logic                                r_v1, r_v2, r_v3;
    logic [63:0]                         r_s1_word;
    logic [63:0]                         r_s1_aw;
    logic                                r_s1_dxt5;
    logic [14:0]                         r_s1_bx, r_s1_by;
    dxt_pkg::t_blk_side                  r_s2_side, r_s3_side, n_s2_side;

    dxt_pkg::t_pipe_ctl                  ctl;
    logic                                m_take;
    logic                                in_acc, alpha_word, colour_acc;
    logic [dxt_pkg::WIDTH_REG_W-1:0]     eff_w;
    logic [CW:0]                         col_inc, row_inc;

    dxt_pkg::t_chan_pal                  pal_r, pal_g, pal_b;
    dxt_pkg::t_alpha_lvl                 lvl;

    assign ctl.adv3   = r_v2 && (!r_v3 || m_take);
    assign ctl.adv2   = r_v1 && (!r_v2 || ctl.adv3);
    assign o_in_ready = !r_v1 || ctl.adv2;

    assign in_acc     = i_in_valid && o_in_ready;
    assign alpha_word = r_fmt && !r_expect;
    assign colour_acc = in_acc && !alpha_word;

    always_comb begin
        if (r_width == '0) begin
            eff_w = dxt_pkg::WIDTH_REG_W'(1);
        end else if (r_width > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = r_width;
        end
        col_inc = (CW + 1)'(r_col) + (CW + 1)'(1);
        row_inc = (CW + 1)'(r_row) + (CW + 1)'(1);
        n_col   = col_inc[CW-1:0];
        n_row   = r_row;
        if (15'(col_inc) >= 15'(eff_w)) begin
            n_col = '0;
            n_row = (row_inc >= MAX_ROWS) ? '0 : row_inc[CW-1:0];
        end
    end

    always_comb begin
        n_s2_side.cidx   = r_s1_word[63:32];
        n_s2_side.aidx   = r_s1_aw[63:16];
        n_s2_side.four   = r_s1_dxt5 || (r_s1_word[15:0] > r_s1_word[31:16]);
        n_s2_side.dxt5   = r_s1_dxt5;
        n_s2_side.base_x = r_s1_bx;
        n_s2_side.base_y = r_s1_by;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= 1'b0;
            r_width  <= dxt_pkg::WIDTH_REG_W'(1);
            r_expect <= 1'b0;
            r_held   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            if (ctl.adv2) begin
                r_v1 <= 1'b0;
            end
            if (colour_acc) begin
                r_v1 <= 1'b1;
            end
            if (ctl.adv2) begin
                r_v2 <= 1'b1;
            end else if (ctl.adv3) begin
                r_v2 <= 1'b0;
            end
            if (ctl.adv3) begin
                r_v3 <= 1'b1;
            end else if (m_take) begin
                r_v3 <= 1'b0;
            end

            if (in_acc) begin
                if (alpha_word) begin
                    r_held   <= i_data_word;
                    r_expect <= 1'b1;
                end else begin
                    r_expect <= 1'b0;
                    r_col    <= n_col;
                    r_row    <= n_row;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    dxt_pkg::CFG_FORMAT_MODE: begin
                        r_fmt    <= i_cfg_data[0];
                        r_expect <= 1'b0;
                    end
                    dxt_pkg::CFG_WIDTH_BLOCKS: begin
                        r_width  <= i_cfg_data;
                        r_col    <= '0;
                        r_row    <= '0;
                        r_expect <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (colour_acc) begin
            r_s1_word <= i_data_word;
            r_s1_aw   <= r_held;
            r_s1_dxt5 <= r_fmt;
            r_s1_bx   <= 15'({r_col, 2'b00});
            r_s1_by   <= 15'({r_row, 2'b00});
        end
        if (ctl.adv2) begin
            r_s2_side <= n_s2_side;
        end
        if (ctl.adv3) begin
            r_s3_side <= r_s2_side;
        end
    end

    dxt_color_lane #(.BITS(5)) u_lane_r (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_c0   (r_s1_word[15:11]),
        .i_c1   (r_s1_word[31:27]),
        .i_four (r_s2_side.four),
        .o_pal  (pal_r)
    );

    dxt_color_lane #(.BITS(6)) u_lane_g (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_c0   (r_s1_word[10:5]),
        .i_c1   (r_s1_word[26:21]),
        .i_four (r_s2_side.four),
        .o_pal  (pal_g)
    );

    dxt_color_lane #(.BITS(5)) u_lane_b (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_c0   (r_s1_word[4:0]),
        .i_c1   (r_s1_word[20:16]),
        .i_four (r_s2_side.four),
        .o_pal  (pal_b)
    );

    dxt_alpha_lane u_lane_a (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a0  (r_s1_aw[7:0]),
        .i_a1  (r_s1_aw[15:8]),
        .o_lvl (lvl)
    );

    dxt_texel_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s3_valid   (r_v3),
        .o_take       (m_take),
        .i_side       (r_s3_side),
        .i_pal_r      (pal_r),
        .i_pal_g      (pal_g),
        .i_pal_b      (pal_b),
        .i_lvl        (lvl),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_block_last (o_block_last)
    );

endmodule

`default_nettype wire

FILE: design/dxt_color_lane.sv
// One colour channel lane: endpoint expansion, then four-entry palette.
// Depends on dxt_pkg.
`default_nettype none

module dxt_color_lane #(
    parameter int BITS = 5
) (
    input  wire logic              i_clk,
    input  wire dxt_pkg::t_pipe_ctl i_ctl,
    input  wire logic [BITS-1:0]   i_c0,
    input  wire logic [BITS-1:0]   i_c1,
    input  wire logic              i_four,
    output dxt_pkg::t_chan_pal     o_pal
);

    logic [7:0]         r_e0, r_e1;
    logic [7:0]         n_e0, n_e1;
    dxt_pkg::t_chan_pal r_pal, n_pal;

    always_comb begin
        if (BITS == 5) begin
            n_e0 = dxt_pkg::exp5(5'(i_c0));
            n_e1 = dxt_pkg::exp5(5'(i_c1));
        end else begin
            n_e0 = dxt_pkg::exp6(6'(i_c0));
            n_e1 = dxt_pkg::exp6(6'(i_c1));
        end
    end

    always_comb begin
        n_pal[0] = r_e0;
        n_pal[1] = r_e1;
        if (i_four) begin
            n_pal[2] = dxt_pkg::div3({1'b0, r_e0, 1'b0} + 10'(r_e1));
            n_pal[3] = dxt_pkg::div3(10'(r_e0) + {1'b0, r_e1, 1'b0});
        end else begin
            n_pal[2] = 8'((9'(r_e0) + 9'(r_e1)) >> 1);
            n_pal[3] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_e0 <= n_e0;
            r_e1 <= n_e1;
        end
        if (i_ctl.adv3) begin
            r_pal <= n_pal;
        end
    end

    assign o_pal = r_pal;

endmodule

`default_nettype wire

FILE: design/dxt_alpha_lane.sv
// DXT5 alpha lane: weighted endpoint sums, then eight-entry alpha table.
// Depends on dxt_pkg.
`default_nettype none

module dxt_alpha_lane (
    input  wire logic               i_clk,
    input  wire dxt_pkg::t_pipe_ctl i_ctl,
    input  wire logic [7:0]         i_a0,
    input  wire logic [7:0]         i_a1,
    output dxt_pkg::t_alpha_lvl     o_lvl
);

    logic [7:0]          r_a0, r_a1;
    logic                r_mode8, n_mode8;
    logic [5:0][10:0]    r_sum, n_sum;
    dxt_pkg::t_alpha_lvl r_lvl, n_lvl;

    always_comb begin
        n_mode8 = i_a0 > i_a1;
        for (int k = 0; k < 6; k++) begin
            if (n_mode8) begin
                n_sum[k] = 11'(i_a0) * 11'(6 - k) + 11'(i_a1) * 11'(k + 1);
            end else if (k < 4) begin
                n_sum[k] = 11'(i_a0) * 11'(4 - k) + 11'(i_a1) * 11'(k + 1);
            end else begin
                n_sum[k] = 11'd0;
            end
        end
    end

    always_comb begin
        n_lvl[0] = r_a0;
        n_lvl[1] = r_a1;
        for (int k = 0; k < 6; k++) begin
            if (r_mode8) begin
                n_lvl[k+2] = dxt_pkg::div7(r_sum[k]);
            end else if (k < 4) begin
                n_lvl[k+2] = dxt_pkg::div5(r_sum[k]);
            end else if (k == 4) begin
                n_lvl[k+2] = 8'd0;
            end else begin
                n_lvl[k+2] = 8'd255;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_a0    <= i_a0;
            r_a1    <= i_a1;
            r_mode8 <= n_mode8;
            r_sum   <= n_sum;
        end
        if (i_ctl.adv3) begin
            r_lvl <= n_lvl;
        end
    end

    assign o_lvl = r_lvl;

endmodule

`default_nettype wire

FILE: design/dxt_texel_merge.sv
// Merge stage: combines the lane palettes with the block indices and emits
// sixteen texels through a registered output. Depends on dxt_pkg.
`default_nettype none

module dxt_texel_merge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s3_valid,
    output logic                     o_take,
    input  wire dxt_pkg::t_blk_side  i_side,
    input  wire dxt_pkg::t_chan_pal  i_pal_r,
    input  wire dxt_pkg::t_chan_pal  i_pal_g,
    input  wire dxt_pkg::t_chan_pal  i_pal_b,
    input  wire dxt_pkg::t_alpha_lvl i_lvl,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic [7:0]               o_alpha,
    output logic [14:0]              o_pixel_x,
    output logic [14:0]              o_pixel_y,
    output logic                     o_block_last
);

    logic                r_busy, n_busy;
    logic [3:0]          r_cnt, n_cnt;
    dxt_pkg::t_blk_side  r_side;
    dxt_pkg::t_chan_pal  r_pal_r, r_pal_g, r_pal_b;
    dxt_pkg::t_alpha_lvl r_lvl;

    logic        r_ov, n_ov;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    logic [14:0] r_px, r_py;
    logic        r_last;

    logic        out_free, emit, emit_last;
    logic [1:0]  ci;
    logic [2:0]  ai;
    logic [7:0]  n_alpha;

    assign out_free  = !r_ov || i_out_ready;
    assign emit      = r_busy && out_free;
    assign emit_last = emit && (r_cnt == 4'd15);
    assign o_take    = i_s3_valid && (!r_busy || emit_last);

    always_comb begin
        ci = r_side.cidx[{r_cnt, 1'b0} +: 2];
        ai = r_side.aidx[6'(r_cnt) * 6'd3 +: 3];
        if (r_side.dxt5) begin
            n_alpha = r_lvl[ai];
        end else if (!r_side.four && ci == 2'd3) begin
            n_alpha = 8'd0;
        end else begin
            n_alpha = 8'd255;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (emit) begin
            n_cnt = r_cnt + 4'd1;
            if (emit_last) begin
                n_busy = 1'b0;
            end
        end
        if (o_take) begin
            n_busy = 1'b1;
            n_cnt  = 4'd0;
        end
        n_ov = r_ov;
        if (emit) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_side  <= i_side;
            r_pal_r <= i_pal_r;
            r_pal_g <= i_pal_g;
            r_pal_b <= i_pal_b;
            r_lvl   <= i_lvl;
        end
        if (emit) begin
            r_red   <= r_pal_r[ci];
            r_green <= r_pal_g[ci];
            r_blue  <= r_pal_b[ci];
            r_alpha <= n_alpha;
            r_px    <= {r_side.base_x[14:2], r_cnt[1:0]};
            r_py    <= {r_side.base_y[14:2], r_cnt[3:2]};
            r_last  <= (r_cnt == 4'd15);
        end
    end

    assign o_out_valid  = r_ov;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_alpha      = r_alpha;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_block_last = r_last;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for dxt_texture_block_decoder_top (DXT1/DXT5 block decoding).
// Random-stalled valid/ready driver and monitor, with a texel predictor and an expected queue.
// Depends on dxt_pkg and the decoder RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int MAX_DIM       = dxt_pkg::MAX_DIM_BLOCKS_DEF;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SWEEP_BLOCKS  = 8;

    localparam bit FMT_DXT1 = 1'b0;
    localparam bit FMT_DXT5 = 1'b1;
    localparam logic [dxt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [dxt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [47:0] ALPHA_RAMP = 48'hFAC688_FAC688;

    typedef enum logic {PLAN_WORD, PLAN_CFG} plan_kind_e;

    typedef struct {
        plan_kind_e                    kind;
        logic [63:0]                   word;
        logic [dxt_pkg::CFG_IDX_W-1:0] idx;
        logic [13:0]                   val;
        bit                            calm;
    } plan_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [14:0] px;
        logic [14:0] py;
        logic        last;
    } texel_t;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic [dxt_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [13:0]                   i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    logic [63:0]                   i_data_word  = '0;
    logic                          i_out_ready  = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [7:0]                    o_red;
    logic [7:0]                    o_green;
    logic [7:0]                    o_blue;
    logic [7:0]                    o_alpha;
    logic [14:0]                   o_pixel_x;
    logic [14:0]                   o_pixel_y;
    logic                          o_block_last;

    plan_t  word_plan[$];
    texel_t pending_texels[$];

    bit          fmt_sel     = FMT_DXT1;
    logic [13:0] width_reg   = 14'd1;
    logic [63:0] held_alpha  = '0;
    bit          colour_next = 1'b0;
    int          blk_col     = 0;
    int          blk_row     = 0;

    bit no_idle   = 1'b0;
    int gap_cnt   = 0;
    int stall_cnt = 0;
    int quiet_cnt = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    dxt_texture_block_decoder_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_block_last (o_block_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic string texel_str(texel_t t);
        return $sformatf("rgba=%0d,%0d,%0d,%0d x=%0d y=%0d last=%0b",
                         t.red, t.green, t.blue, t.alpha, t.px, t.py, t.last);
    endfunction

    function automatic void report_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void add_word(logic [63:0] w);
        word_plan.push_back('{kind: PLAN_WORD, word: w, idx: '0, val: '0, calm: 1'b0});
    endfunction

    function automatic void add_cfg(logic [dxt_pkg::CFG_IDX_W-1:0] idx, logic [13:0] val,
                                    bit calm_ph);
        word_plan.push_back('{kind: PLAN_CFG, word: '0, idx: idx, val: val, calm: calm_ph});
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: w[31:16] = w[15:0];
            1: w[15:8]  = w[7:0];
            default: ;
        endcase
        return w;
    endfunction

    function automatic void apply_cfg(logic [dxt_pkg::CFG_IDX_W-1:0] idx, logic [13:0] val);
        if (idx == dxt_pkg::CFG_FORMAT_MODE) begin
            fmt_sel     = val[0];
            colour_next = 1'b0;
        end else if (idx == dxt_pkg::CFG_WIDTH_BLOCKS) begin
            width_reg   = val;
            blk_col     = 0;
            blk_row     = 0;
            colour_next = 1'b0;
        end
    endfunction

    function automatic void decode_block(logic [63:0] w);
        int     pal[4][3];
        int     alv[8];
        int     raw, c0, c1, a0, a1, ci, av, eff_w;
        bit     four;
        texel_t t;
        if (fmt_sel == FMT_DXT5 && !colour_next) begin
            held_alpha  = w;
            colour_next = 1'b1;
            return;
        end
        colour_next = 1'b0;
        c0 = int'(w[15:0]);
        c1 = int'(w[31:16]);
        for (int k = 0; k < 2; k++) begin
            raw = (k == 0) ? c0 : c1;
            pal[k][0] = (255 * ((raw >> 11) & 31)) / 31;
            pal[k][1] = (255 * ((raw >> 5) & 63)) / 63;
            pal[k][2] = (255 * (raw & 31)) / 31;
        end
        four = (fmt_sel == FMT_DXT5) || (c0 > c1);
        for (int ch = 0; ch < 3; ch++) begin
            if (four) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
        end
        a0 = int'(held_alpha[7:0]);
        a1 = int'(held_alpha[15:8]);
        alv[0] = a0;
        alv[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k <= 6; k++) alv[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end else begin
            for (int k = 1; k <= 4; k++) alv[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            alv[6] = 0;
            alv[7] = 255;
        end
        for (int k = 0; k < 16; k++) begin
            ci = int'(w[32 + 2 * k +: 2]);
            if (fmt_sel == FMT_DXT5) av = alv[held_alpha[16 + 3 * k +: 3]];
            else av = (ci == 3 && !four) ? 0 : 255;
            t.red   = 8'(pal[ci][0]);
            t.green = 8'(pal[ci][1]);
            t.blue  = 8'(pal[ci][2]);
            t.alpha = 8'(av);
            t.px    = 15'(blk_col * 4 + k % 4);
            t.py    = 15'(blk_row * 4 + k / 4);
            t.last  = (k == 15);
            pending_texels.push_back(t);
        end
        eff_w = (width_reg == 0) ? 1 : (int'(width_reg) > MAX_DIM) ? MAX_DIM : int'(width_reg);
        blk_col++;
        if (blk_col >= eff_w) begin
            blk_col = 0;
            blk_row++;
            if (blk_row >= MAX_DIM) blk_row = 0;
        end
    endfunction

    always @(posedge i_clk) begin : drive_p
        logic                          fire;
        logic                          nxt_valid;
        logic                          nxt_we;
        logic [63:0]                   nxt_word;
        logic [dxt_pkg::CFG_IDX_W-1:0] nxt_idx;
        logic [13:0]                   nxt_data;
        fire      = i_in_valid && o_in_ready;
        nxt_valid = i_in_valid;
        nxt_word  = i_data_word;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_index;
        nxt_data  = i_cfg_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (fire) begin
                decode_block(i_data_word);
                void'(word_plan.pop_front());
                gap_cnt   = no_idle ? 0 : $urandom_range(0, 16);
                nxt_valid = 1'b0;
            end
            if (fire || pending_texels.size() != 0) quiet_cnt = 0;
            else if (quiet_cnt < SETTLE_CYCLES) quiet_cnt++;
            if (!nxt_valid) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (word_plan.size() != 0) begin
                    if (word_plan[0].kind == PLAN_WORD) begin
                        nxt_valid = 1'b1;
                        nxt_word  = word_plan[0].word;
                    end else if (quiet_cnt >= SETTLE_CYCLES) begin
                        nxt_we   = 1'b1;
                        nxt_idx  = word_plan[0].idx;
                        nxt_data = word_plan[0].val;
                        apply_cfg(word_plan[0].idx, word_plan[0].val);
                        no_idle  = word_plan[0].calm;
                        void'(word_plan.pop_front());
                        quiet_cnt = 0;
                    end
                end
            end
        end
        i_in_valid  <= nxt_valid;
        i_data_word <= nxt_word;
        i_cfg_we    <= nxt_we;
        i_cfg_index <= nxt_idx;
        i_cfg_data  <= nxt_data;
    end

    always @(posedge i_clk) begin : watch_p
        texel_t got;
        texel_t want;
        logic   nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_red, o_green, o_blue, o_alpha, o_pixel_x, o_pixel_y, o_block_last};
                if (pending_texels.size() == 0) begin
                    report_error({"unexpected texel ", texel_str(got)});
                end else begin
                    want = pending_texels.pop_front();
                    if (got !== want) begin
                        report_error({"expected ", texel_str(want), " got ", texel_str(got)});
                    end
                end
                stall_cnt = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_out_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          rand_cnt;
        int          n_words;
        bit          calm_ph;
        logic [13:0] wv;
        rand_cnt = 0;

        add_word(64'h0);
        add_word(64'hFFFF_FFFF_FFFF_FFFF);
        add_word({32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
        add_word({32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
        add_word({32'h1B1B_1B1B, 16'h07E0, 16'hF800});
        add_word({32'hE4E4_E4E4, 16'hA5A5, 16'hA5A5});

        add_cfg(dxt_pkg::CFG_WIDTH_BLOCKS, 14'd3, 1'b0);
        add_cfg(dxt_pkg::CFG_FORMAT_MODE, {13'($urandom), FMT_DXT5}, 1'b0);
        add_word({ALPHA_RAMP, 8'h00, 8'hFF});
        add_word({32'hE4E4_E4E4, 16'hF800, 16'h001F});
        add_word({ALPHA_RAMP, 8'hFF, 8'h00});
        add_word({32'h1B1B_1B1B, 16'hFFFF, 16'h0000});
        add_word({ALPHA_RAMP, 8'h80, 8'h80});
        add_word({32'hE4E4_E4E4, 16'h1234, 16'h1234});
        add_word({48'hFFFF_FFFF_FFFF, 8'h37, 8'hC9});
        add_word(64'hFFFF_FFFF_FFFF_FFFF);

        add_cfg(CFG_SPARE_A, 14'h0000, 1'b0);
        add_cfg(CFG_SPARE_B, 14'h3FFF, 1'b0);
        add_word(rand_word());
        add_word(rand_word());
        add_cfg(dxt_pkg::CFG_FORMAT_MODE, {13'($urandom), FMT_DXT5}, 1'b0);
        add_word(rand_word());
        add_word(rand_word());

        add_cfg(dxt_pkg::CFG_FORMAT_MODE, {13'($urandom), FMT_DXT1}, 1'b0);
        add_cfg(dxt_pkg::CFG_WIDTH_BLOCKS, 14'(MAX_DIM), 1'b0);
        repeat (3) add_word(rand_word());

        add_cfg(dxt_pkg::CFG_WIDTH_BLOCKS, 14'h3FFF, 1'b1);
        repeat (SWEEP_BLOCKS) add_word(rand_word());
        add_cfg(dxt_pkg::CFG_WIDTH_BLOCKS, 14'h0000, 1'b1);
        repeat (SWEEP_BLOCKS) add_word(rand_word());

        while (rand_cnt < RANDOM_ITEMS) begin
            calm_ph = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) wv = 14'($urandom_range(0, 16383));
            else wv = 14'($urandom_range(1, 5));
            add_cfg(dxt_pkg::CFG_WIDTH_BLOCKS, wv, calm_ph);
            if ($urandom_range(0, 1) == 1) begin
                add_cfg(dxt_pkg::CFG_FORMAT_MODE, 14'($urandom), calm_ph);
            end
            n_words = $urandom_range(6, 40);
            repeat (n_words) add_word(rand_word());
            rand_cnt += n_words;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_plan.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_texels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/dxt_pkg.sv
design/dxt_color_lane.sv
design/dxt_alpha_lane.sv
design/dxt_texel_merge.sv
design/dxt_texture_block_decoder_top.sv
tb/tb_top.sv
